// ===== sv/ccc_pkg.sv =====
// Shared constants for the three-point circumference pipeline.
package ccc_pkg;

    // Digit width of the partial-product multipliers
    localparam int DIG_W = 32;

    // Result format and internal guard bits
    localparam int OUT_BITS = 48;
    localparam int GUARD    = 16;

    // Quotient bits of the diameter divide; a quotient at or above 2^QUO_BITS saturates
    localparam int QUO_BITS = OUT_BITS - 1 + GUARD;

    // pi scaled by 2^62, rounded to nearest
    localparam int          PI_W   = 64;
    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

    // Final scaling of diameter * pi back to the output format
    localparam int ROUND_SH = 62 + GUARD;

endpackage

// ===== sv/ccc_mul.sv =====
// Two-stage multi-lane multiplier built from 32x32 partial products.
module ccc_mul import ccc_pkg::*; #(
    parameter int LANES = 1,
    parameter int A_W   = 33,
    parameter int B_W   = 33,
    parameter int SB_W  = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [LANES-1:0][A_W-1:0]       i_a,
    input  logic [LANES-1:0][B_W-1:0]       i_b,
    input  logic [SB_W-1:0]                 i_sb,
    output logic                            o_valid,
    output logic [LANES-1:0][A_W+B_W-1:0]   o_p,
    output logic [SB_W-1:0]                 o_sb
);

    localparam int NA  = (A_W + DIG_W - 1) / DIG_W;
    localparam int NB  = (B_W + DIG_W - 1) / DIG_W;
    localparam int P_W = A_W + B_W;

    logic [LANES-1:0][NA*DIG_W-1:0] a_ext;
    logic [LANES-1:0][NB*DIG_W-1:0] b_ext;
    logic [2*DIG_W-1:0]             n_pp [LANES][NA][NB];
    logic [2*DIG_W-1:0]             r_pp [LANES][NA][NB];
    logic [LANES-1:0][P_W-1:0]      n_p;
    logic [LANES-1:0][P_W-1:0]      r_p;
    logic [1:0]                     r_vld;
    logic [SB_W-1:0]                r_sb1;
    logic [SB_W-1:0]                r_sb2;

    // Stage 1: all digit products
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            a_ext[l] = (NA*DIG_W)'(i_a[l]);
            b_ext[l] = (NB*DIG_W)'(i_b[l]);
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    n_pp[l][i][j] = (2*DIG_W)'(a_ext[l][i*DIG_W +: DIG_W])
                                  * (2*DIG_W)'(b_ext[l][j*DIG_W +: DIG_W]);
                end
            end
        end
    end

    // Stage 2: weighted sum of the digit products
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_p[l] = '0;
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    n_p[l] = n_p[l] + (P_W'(r_pp[l][i][j]) << ((i + j) * DIG_W));
                end
            end
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[0], i_valid};
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp  <= n_pp;
            r_sb1 <= i_sb;
            r_p   <= n_p;
            r_sb2 <= r_sb1;
        end
    end

    assign o_valid = r_vld[1];
    assign o_p     = r_p;
    assign o_sb    = r_sb2;

endmodule

// ===== sv/ccc_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module ccc_sqrt import ccc_pkg::*; #(
    parameter int RAD_W = 230,
    parameter int SB_W  = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [RAD_W-1:0]     i_rad,
    input  logic [SB_W-1:0]      i_sb,
    output logic                 o_valid,
    output logic [RAD_W/2-1:0]   o_root,
    output logic [SB_W-1:0]      o_sb
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int TRY_W  = ROOT_W + 4;

    logic                r_vld  [ROOT_W];
    logic [RAD_W-1:0]    r_rad  [ROOT_W];
    logic [REM_W-1:0]    r_rem  [ROOT_W];
    logic [ROOT_W-1:0]   r_root [ROOT_W];
    logic [SB_W-1:0]     r_sb   [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic                vld_in;
        logic [RAD_W-1:0]    rad_in;
        logic [REM_W-1:0]    rem_in;
        logic [ROOT_W-1:0]   root_in;
        logic [SB_W-1:0]     sb_in;
        logic [TRY_W-1:0]    cur;
        logic [TRY_W-1:0]    trial;
        logic                take;

        if (k == 0) begin : g_first
            assign vld_in  = i_valid;
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign sb_in   = i_sb;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign rad_in  = r_rad[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign sb_in   = r_sb[k-1];
        end

        // Bring down the next bit pair and try root*4+1
        assign cur   = {rem_in, rad_in[RAD_W-1 -: 2]};
        assign trial = TRY_W'({root_in, 2'b01});
        assign take  = (cur >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= rad_in << 2;
                r_rem[k]  <= take ? REM_W'(cur - trial) : REM_W'(cur);
                r_root[k] <= {root_in[ROOT_W-2:0], take};
                r_sb[k]   <= sb_in;
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_sb    = r_sb[ROOT_W-1];

endmodule

// ===== sv/ccc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module ccc_div import ccc_pkg::*; #(
    parameter int N_W  = 115,
    parameter int D_W  = 66,
    parameter int Q_W  = 63,
    parameter int SB_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [N_W-1:0]    i_num,
    input  logic [D_W-1:0]    i_den,
    input  logic [SB_W-1:0]   i_sb,
    output logic              o_valid,
    output logic [Q_W-1:0]    o_quo,
    output logic [SB_W-1:0]   o_sb
);

    localparam int CW = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

    logic              r_vld [Q_W];
    logic [N_W-1:0]    r_rem [Q_W];
    logic [D_W-1:0]    r_den [Q_W];
    logic [Q_W-1:0]    r_quo [Q_W];
    logic [SB_W-1:0]   r_sb  [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        localparam int SH = Q_W - 1 - k;
        logic              vld_in;
        logic [N_W-1:0]    rem_in;
        logic [D_W-1:0]    den_in;
        logic [Q_W-1:0]    quo_in;
        logic [SB_W-1:0]   sb_in;
        logic [CW-1:0]     cur;
        logic [CW-1:0]     sub;
        logic              take;

        if (k == 0) begin : g_first
            assign vld_in = i_valid;
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
            assign sb_in  = i_sb;
        end else begin : g_next
            assign vld_in = r_vld[k-1];
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
            assign sb_in  = r_sb[k-1];
        end

        // Subtract the shifted divisor when it fits
        assign cur  = CW'(rem_in);
        assign sub  = CW'(den_in) << SH;
        assign take = (cur >= sub);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= take ? N_W'(cur - sub) : rem_in;
                r_den[k] <= den_in;
                r_quo[k] <= {quo_in[Q_W-2:0], take};
                r_sb[k]  <= sb_in;
            end
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_quo   = r_quo[Q_W-1];
    assign o_sb    = r_sb[Q_W-1];

endmodule

// ===== sv/circumcircle_circumference.sv =====
// Circumference of the circle through three points, fully pipelined.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  in      | i_valid / o_ready   | i_first_x/y, i_second_x/y, i_third_x/y (Q.16)
//  out     | o_valid / i_ready   | o_circumference (Q32.16), o_degenerate
//
// The pipeline depth is set mostly by the
// one-bit-per-stage square root (3*COORD_BITS+19 stages) and the 63-stage divide.
// One transaction is accepted per cycle while o_ready is high. Reset clears only the valid bits.
// When the output holds a result that is not taken, the whole pipeline holds.
module circumcircle_circumference import ccc_pkg::*; #(
    parameter int COORD_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_BITS-1:0]  i_first_x,
    input  logic signed [COORD_BITS-1:0]  i_first_y,
    input  logic signed [COORD_BITS-1:0]  i_second_x,
    input  logic signed [COORD_BITS-1:0]  i_second_y,
    input  logic signed [COORD_BITS-1:0]  i_third_x,
    input  logic signed [COORD_BITS-1:0]  i_third_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [OUT_BITS-1:0]           o_circumference,
    output logic                          o_degenerate
);

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int L_W    = 3 * PROD_W;
    localparam int RAD_W  = L_W + 2 * GUARD;
    localparam int ROOT_W = RAD_W / 2;
    localparam int SAT_W  = (ROOT_W > PROD_W + QUO_BITS) ? ROOT_W : PROD_W + QUO_BITS;
    localparam int PRD_W  = QUO_BITS + PI_W;
    localparam int RND_W  = PRD_W + 1;
    localparam int SHR_W  = RND_W - ROUND_SH;

    localparam int BX = 0;
    localparam int BY = 1;
    localparam int CX = 2;
    localparam int CY = 3;
    localparam int DX = 4;
    localparam int DY = 5;

    logic en;

    // Edge vectors and their magnitudes
    logic signed [DIFF_W-1:0] dif    [6];
    logic        [DIFF_W-1:0] n1_mag [6];
    logic        [DIFF_W-1:0] r1_mag [6];
    logic        [3:0]        r1_sgn;
    logic                     r1_vld;

    assign dif[BX] = DIFF_W'(i_second_x) - DIFF_W'(i_first_x);
    assign dif[BY] = DIFF_W'(i_second_y) - DIFF_W'(i_first_y);
    assign dif[CX] = DIFF_W'(i_third_x)  - DIFF_W'(i_first_x);
    assign dif[CY] = DIFF_W'(i_third_y)  - DIFF_W'(i_first_y);
    assign dif[DX] = DIFF_W'(i_third_x)  - DIFF_W'(i_second_x);
    assign dif[DY] = DIFF_W'(i_third_y)  - DIFF_W'(i_second_y);

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            n1_mag[k] = dif[k][DIFF_W-1] ? DIFF_W'(-dif[k]) : DIFF_W'(dif[k]);
        end
    end

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_mag <= n1_mag;
            r1_sgn <= {dif[CY][DIFF_W-1], dif[CX][DIFF_W-1],
                       dif[BY][DIFF_W-1], dif[BX][DIFF_W-1]};
        end
    end

    // Cross-product terms and squared edge lengths
    logic [7:0][DIFF_W-1:0] m1_a;
    logic [7:0][DIFF_W-1:0] m1_b;
    logic [7:0][PROD_W-1:0] m1_p;
    logic [3:0]             m1_sgn;
    logic                   m1_vld;

    assign m1_a[0] = r1_mag[BX];  assign m1_b[0] = r1_mag[CY];
    assign m1_a[1] = r1_mag[BY];  assign m1_b[1] = r1_mag[CX];
    assign m1_a[2] = r1_mag[BX];  assign m1_b[2] = r1_mag[BX];
    assign m1_a[3] = r1_mag[BY];  assign m1_b[3] = r1_mag[BY];
    assign m1_a[4] = r1_mag[CX];  assign m1_b[4] = r1_mag[CX];
    assign m1_a[5] = r1_mag[CY];  assign m1_b[5] = r1_mag[CY];
    assign m1_a[6] = r1_mag[DX];  assign m1_b[6] = r1_mag[DX];
    assign m1_a[7] = r1_mag[DY];  assign m1_b[7] = r1_mag[DY];

    ccc_mul #(.LANES(8), .A_W(DIFF_W), .B_W(DIFF_W), .SB_W(4)) u_mul_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r1_vld),
        .i_a     (m1_a),
        .i_b     (m1_b),
        .i_sb    (r1_sgn),
        .o_valid (m1_vld),
        .o_p     (m1_p),
        .o_sb    (m1_sgn)
    );

    // |cross| from signed terms, squared lengths summed
    logic              neg1;
    logic              neg2;
    logic [PROD_W-1:0] n2_x;
    logic [PROD_W-1:0] r2_x;
    logic [PROD_W-1:0] r2_lb;
    logic [PROD_W-1:0] r2_lc;
    logic [PROD_W-1:0] r2_ld;
    logic              r2_deg;
    logic              r2_vld;

    assign neg1 = m1_sgn[BX] ^ m1_sgn[CY];
    assign neg2 = m1_sgn[BY] ^ m1_sgn[CX];

    always_comb begin
        if (neg1 != neg2) begin
            n2_x = m1_p[0] + m1_p[1];
        end else if (m1_p[0] >= m1_p[1]) begin
            n2_x = m1_p[0] - m1_p[1];
        end else begin
            n2_x = m1_p[1] - m1_p[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= m1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_x   <= n2_x;
            r2_deg <= (n2_x == '0);
            r2_lb  <= m1_p[2] + m1_p[3];
            r2_lc  <= m1_p[4] + m1_p[5];
            r2_ld  <= m1_p[6] + m1_p[7];
        end
    end

    // Product of the three squared lengths
    logic [0:0][2*PROD_W-1:0]   m2_p;
    logic [PROD_W:0]            m2_sb;
    logic [PROD_W-1:0]          m2_ld;
    logic                       m2_vld;
    logic [0:0][L_W-1:0]        m3_p;
    logic [PROD_W:0]            m3_sb;
    logic                       m3_vld;

    ccc_mul #(.LANES(1), .A_W(PROD_W), .B_W(PROD_W), .SB_W(2*PROD_W+1)) u_mul_bc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_vld),
        .i_a     (r2_lb),
        .i_b     (r2_lc),
        .i_sb    ({r2_x, r2_deg, r2_ld}),
        .o_valid (m2_vld),
        .o_p     (m2_p),
        .o_sb    ({m2_sb, m2_ld})
    );

    ccc_mul #(.LANES(1), .A_W(2*PROD_W), .B_W(PROD_W), .SB_W(PROD_W+1)) u_mul_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (m2_vld),
        .i_a     (m2_p),
        .i_b     (m2_ld),
        .i_sb    (m2_sb),
        .o_valid (m3_vld),
        .o_p     (m3_p),
        .o_sb    (m3_sb)
    );

    // Square root of the length product with guard bits
    logic [ROOT_W-1:0] sq_root;
    logic [PROD_W:0]   sq_sb;
    logic              sq_vld;

    ccc_sqrt #(.RAD_W(RAD_W), .SB_W(PROD_W+1)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (m3_vld),
        .i_rad   ({m3_p[0], (2*GUARD)'(0)}),
        .i_sb    (m3_sb),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_sb    (sq_sb)
    );

    // Huge-circle check: diameter quotient would reach 2^QUO_BITS
    logic [PROD_W-1:0] sq_x;
    logic              sq_deg;
    logic [ROOT_W-1:0] r3_root;
    logic [PROD_W-1:0] r3_x;
    logic              r3_deg;
    logic              r3_sat;
    logic              r3_vld;

    assign sq_x   = sq_sb[PROD_W:1];
    assign sq_deg = sq_sb[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_root <= sq_root;
            r3_x    <= sq_x;
            r3_deg  <= sq_deg;
            r3_sat  <= (SAT_W'(sq_root) >= (SAT_W'(sq_x) << QUO_BITS));
        end
    end

    // Diameter = root / |cross|
    logic [QUO_BITS-1:0] dv_quo;
    logic [1:0]          dv_sb;
    logic                dv_vld;

    ccc_div #(.N_W(ROOT_W), .D_W(PROD_W), .Q_W(QUO_BITS), .SB_W(2)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_vld),
        .i_num   (r3_root),
        .i_den   (r3_x),
        .i_sb    ({r3_deg, r3_sat}),
        .o_valid (dv_vld),
        .o_quo   (dv_quo),
        .o_sb    (dv_sb)
    );

    // Diameter times pi
    logic [0:0][PRD_W-1:0] m4_p;
    logic [1:0]            m4_sb;
    logic                  m4_vld;

    ccc_mul #(.LANES(1), .A_W(QUO_BITS), .B_W(PI_W), .SB_W(2)) u_mul_pi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dv_vld),
        .i_a     (dv_quo),
        .i_b     (PI_Q62),
        .i_sb    (dv_sb),
        .o_valid (m4_vld),
        .o_p     (m4_p),
        .o_sb    (m4_sb)
    );

    // Round, scale, saturate, or zero when degenerate; output register
    logic [RND_W-1:0]    rnd;
    logic [SHR_W-1:0]    scaled;
    logic                ovf;
    logic [OUT_BITS-1:0] n_circ;
    logic                r_out_vld;
    logic [OUT_BITS-1:0] r_circ;
    logic                r_deg;

    assign rnd    = RND_W'(m4_p[0]) + (RND_W'(1) << (ROUND_SH - 1));
    assign scaled = SHR_W'(rnd >> ROUND_SH);
    assign ovf    = |scaled[SHR_W-1:OUT_BITS];

    always_comb begin
        if (m4_sb[1]) begin
            n_circ = '0;
        end else if (m4_sb[0] || ovf) begin
            n_circ = '1;
        end else begin
            n_circ = scaled[OUT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= m4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_circ <= n_circ;
            r_deg  <= m4_sb[1];
        end
    end

    assign o_valid         = r_out_vld;
    assign o_circumference = r_circ;
    assign o_degenerate    = r_deg;

endmodule
